[design/rmsm_pkg.sv]
// ----------------------------------------------------------------------------
// rmsm_pkg
// Types and constants shared by the RMS level meter modules.
// ----------------------------------------------------------------------------
package rmsm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SUM_W   = 59;
    localparam int CNT_W   = 14;
    localparam int MS_W    = 32;
    localparam int LVL_W   = 16;
    localparam int COEF_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_EMPTY = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [IDX_W-1:0] REG_ATTACK   = 2'd0;
    localparam logic [IDX_W-1:0] REG_RELEASE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd2;

    typedef struct packed {
        logic [1:0]             command;
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   last_in_block;
    } t_in_word;

    typedef struct packed {
        logic [LVL_W-1:0] meter_level;
        logic             was_rising;
    } t_out_word;

    // Job handed from the front end to the back end.
    typedef enum logic [1:0] {
        JOB_BLOCK = 2'd0,
        JOB_EMPTY = 2'd1,
        JOB_CLEAR = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind        kind;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SQRT,
        ST_OUT
    } t_back_state;

endpackage

[design/rmsm_front.sv]
// ----------------------------------------------------------------------------
// rmsm_front
// Accumulates squared samples per block and issues block-end, empty-block and reset jobs.
// ----------------------------------------------------------------------------
module rmsm_front #(
    parameter int MAX_BLOCK_FRAMES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_command,
    input  logic [rmsm_pkg::SAMPLE_BITS-1:0]   i_left,
    input  logic [rmsm_pkg::SAMPLE_BITS-1:0]   i_right,
    input  logic                               i_last,
    input  logic                               i_stereo,
    output logic                               o_job_valid,
    input  logic                               i_job_stall,
    output rmsm_pkg::t_job                     o_job
);
    import rmsm_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS;
    localparam int CAP_RAW = 2 * MAX_BLOCK_FRAMES;
    localparam int CAP = (CAP_RAW < 16383) ? CAP_RAW : 16383;
    localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_jv, n_jv;
    t_job             r_job, n_job;

    logic [SAMPLE_BITS-1:0] mag_l, mag_r;
    logic [SQ_W-1:0]        sq_l, sq_r;
    logic [SUM_W:0]         s1, s2, s1c;
    logic [CNT_W:0]         cnt_next;
    logic                   fits, accept;

    assign o_stall     = r_jv && i_job_stall;
    assign accept      = i_valid && !o_stall;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;

    always_comb begin
        mag_l = i_left[SAMPLE_BITS-1] ? (~i_left + 1'b1) : i_left;
        mag_r = i_right[SAMPLE_BITS-1] ? (~i_right + 1'b1) : i_right;
        sq_l  = mag_l * mag_l;
        sq_r  = i_stereo ? mag_r * mag_r : '0;
        s1    = {1'b0, r_sum} + (SUM_W+1)'(sq_l);
        s1c   = (s1 > SUM_MAX) ? SUM_MAX : s1;
        s2    = s1c + (SUM_W+1)'(sq_r);
        if (s2 > SUM_MAX) s2 = SUM_MAX;
        cnt_next = {1'b0, r_cnt} + (i_stereo ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
        fits  = cnt_next <= (CNT_W+1)'(CAP);
    end

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_jv  = r_jv && i_job_stall;
        n_job = r_job;
        if (accept) begin
            case (i_command)
                CMD_FRAME: begin
                    if (fits) begin
                        n_sum = s2[SUM_W-1:0];
                        n_cnt = cnt_next[CNT_W-1:0];
                    end
                    if (i_last) begin
                        n_jv        = 1'b1;
                        n_job.kind  = JOB_BLOCK;
                        n_job.sum   = fits ? s2[SUM_W-1:0] : r_sum;
                        n_job.count = fits ? cnt_next[CNT_W-1:0] : r_cnt;
                        n_sum = '0;
                        n_cnt = '0;
                    end
                end
                CMD_EMPTY, CMD_RESET: begin
                    n_jv        = 1'b1;
                    n_job.kind  = (i_command == CMD_EMPTY) ? JOB_EMPTY : JOB_CLEAR;
                    n_job.sum   = '0;
                    n_job.count = '0;
                    n_sum = '0;
                    n_cnt = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_jv  <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
            r_jv  <= n_jv;
        end
        r_job <= n_job;
    end
endmodule

[design/rmsm_queue.sv]
// ----------------------------------------------------------------------------
// rmsm_queue
// Small FIFO of block jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module rmsm_queue #(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rmsm_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_pop,
    output rmsm_pkg::t_job o_job
);
    import rmsm_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_job                r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wp, r_rp;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic                push, pop;

    assign o_stall = r_cnt == (DEPTH_LOG2+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

[design/rmsm_back.sv]
// ----------------------------------------------------------------------------
// rmsm_back
// Block-end math: serial divide, blend, serial square root.
// ----------------------------------------------------------------------------
module rmsm_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    output logic                    o_job_pop,
    input  rmsm_pkg::t_job          i_job,
    input  logic [15:0]             i_attack,
    input  logic [15:0]             i_release,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rmsm_pkg::t_out_word     o_data
);
    import rmsm_pkg::*;

    localparam int SQ_FRAC = 2 * (SAMPLE_BITS - 1);
    localparam int SH_R = (SQ_FRAC >= 32) ? SQ_FRAC - 32 : 0;
    localparam int SH_L = (SQ_FRAC < 32) ? 32 - SQ_FRAC : 0;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    t_back_state r_st, n_st;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic [MS_W-1:0]   r_ms, r_mean;
    logic [MS_W-1:0]   r_root;
    logic [MS_W-1:0]   r_x;
    logic [MS_W-1:0]   r_bit;
    logic              r_rise;
    t_out_word         r_out;
    logic              r_ov;

    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic [SUM_W-1:0]  q_next;
    logic [CNT_W:0]    rem_next;
    logic [SUM_W+SH_L:0] mean_full;
    logic [MS_W-1:0]   mean_sat;
    logic              rise;
    logic [COEF_W-1:0] coef;
    logic [48:0]       blend;

    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        rem_sh    = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
        q_bit     = (r_den != '0) && (rem_sh >= {1'b0, r_den});
        q_next    = {r_quo[SUM_W-2:0], q_bit};
        rem_next  = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
        // mean from the quotient as it stands after the final step
        mean_full = ({1'b0, q_next} << SH_L) >> SH_R;
        mean_sat  = (mean_full > (SUM_W+SH_L+1)'(33'hFFFFFFFF)) ? '1 : mean_full[MS_W-1:0];
        rise      = r_mean > r_ms;
        coef      = rise ? i_attack : i_release;
        blend     = 49'(r_ms) * 49'(coef) + 49'(r_mean) * (49'd65536 - 49'(coef));
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_job_valid && !(r_ov && i_stall)) begin
                if (i_job.kind == JOB_BLOCK) n_st = ST_DIV;
                else if (i_job.kind == JOB_EMPTY) n_st = ST_OUT;
            end
            ST_DIV:  if (r_step == STEP_W'(DIV_STEPS - 1)) n_st = ST_MUL;
            ST_MUL:  n_st = ST_SQRT;
            ST_SQRT: if (r_bit == 32'd1) n_st = ST_OUT;
            ST_OUT:  if (!(r_ov && i_stall)) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_job_pop = (r_st == ST_IDLE) && i_job_valid && !(r_ov && i_stall);
    end

    logic [MS_W-1:0] sq_root_ext, sq_sum;
    always_comb begin
        sq_root_ext = r_root;
        sq_sum      = sq_root_ext + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ov   <= 1'b0;
            r_ms   <= '0;
        end else begin
            r_st <= n_st;
            // hold while stalled, load when a word leaves the output state
            r_ov <= (r_ov && i_stall) || (r_st == ST_OUT);
            case (r_st)
                ST_IDLE: if (o_job_pop) begin
                    if (i_job.kind == JOB_CLEAR) r_ms <= '0;
                end
                ST_MUL: r_ms <= blend[47:16];
                default: ;
            endcase
        end
        case (r_st)
            ST_IDLE: begin
                r_quo  <= i_job.sum;
                r_den  <= i_job.count;
                r_rem  <= '0;
                r_step <= '0;
                r_root <= '0;
                r_rise <= 1'b0;
            end
            ST_DIV: begin
                // shift one quotient bit per cycle
                r_rem  <= rem_next;
                r_quo  <= q_next;
                r_step <= r_step + 1'b1;
            end
            ST_MUL: begin
                r_rise <= rise;
                r_x    <= blend[47:16];
                r_bit  <= 32'h4000_0000;
                r_root <= '0;
            end
            ST_SQRT: begin
                if ({1'b0, r_x} >= {1'b0, sq_sum}) begin
                    r_x    <= r_x - sq_sum;
                    r_root <= (sq_root_ext >> 1) + r_bit;
                end else begin
                    r_root <= sq_root_ext >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_OUT: if (!(r_ov && i_stall)) begin
                r_out.meter_level <= r_root[LVL_W-1:0];
                r_out.was_rising  <= r_rise;
            end
            default: ;
        endcase
        if (r_st == ST_DIV && r_step == STEP_W'(DIV_STEPS - 1)) r_mean <= mean_sat;
    end
endmodule

[design/rms_level_meter_attack_release_unit.sv]
// ----------------------------------------------------------------------------
// rms_level_meter_attack_release_unit
// RMS level meter with separate attack and release smoothing.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with one frame or command per word.
// Frames are summed at one word per cycle when not stalled; the word marked
// last in block and the empty-block and reset commands queue a back-end job.
// Output channel: o_out_valid / i_out_stall carries one level word per block
// or empty-block command.
// A block's job passes through the job register and the queue and is taken
// by the back end; then come the serial division (one quotient bit a cycle),
// the blend, the square root and the loading of the output word. An empty-block
// word goes from taking the job straight to loading the output word.
// Throughput: one frame per cycle while the four-entry job queue has room;
// the back end takes no new job until it has loaded the output word of the last.
// Reset (i_rst_n low, synchronous) clears sums, smoothed value and queue,
// sets attack and release to zero and channels to stereo.
// While the receiver stalls, the level word holds and jobs pile in the queue;
// once it is full and a job waits in the job register, the input stalls.
// Configuration: write i_cfg_we with i_cfg_index and i_cfg_data while idle.
// ----------------------------------------------------------------------------
module rms_level_meter_attack_release_unit #(
    parameter int MAX_BLOCK_FRAMES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rmsm_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rmsm_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import rmsm_pkg::*;

    logic [15:0] r_attack, r_release;
    logic [1:0]  r_channels;
    logic        jv, js, qv, qpop;
    t_job        job, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack   <= '0;
            r_release  <= '0;
            r_channels <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ATTACK:   r_attack   <= i_cfg_data;
                REG_RELEASE:  r_release  <= i_cfg_data;
                REG_CHANNELS: r_channels <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    rmsm_front #(
        .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_stall(o_in_stall),
        .i_command(i_in_data.command),
        .i_left(i_in_data.left_sample),
        .i_right(i_in_data.right_sample),
        .i_last(i_in_data.last_in_block),
        .i_stereo(r_channels >= 2'd2),
        .o_job_valid(jv), .i_job_stall(js), .o_job(job)
    );

    rmsm_queue #(.DEPTH_LOG2(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(jv), .o_stall(js), .i_job(job),
        .o_valid(qv), .i_pop(qpop), .o_job(qjob)
    );

    rmsm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(qv), .o_job_pop(qpop), .i_job(qjob),
        .i_attack(r_attack), .i_release(r_release),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_data(o_out_data)
    );
endmodule
